/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion helpers for the attribute stream parser
// Clocked property checks that are compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check prop at every rising edge of clk, ignored while rst_n is low
`define SDP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("sdp assertion failed");
// check prop at every rising edge of clk, reset included
`define SDP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("sdp assertion failed");
`else
`define SDP_ASSERT(lbl, clk, rst_n, prop)
`define SDP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/core/sdp_pkg.sv */
// ----------------------------------------------------------------------------
// sdp_pkg - shared types for the attribute stream parser
// Parse phases, header parser state and size-index codes.
// ----------------------------------------------------------------------------
package sdp_pkg;

	// parse phase of the nested element walk
	typedef enum logic [2:0] {
		PH_LIST   = 3'd0,
		PH_RECORD = 3'd1,
		PH_IDHDR  = 3'd2,
		PH_ID     = 3'd3,
		PH_VALHDR = 3'd4,
		PH_VALUE  = 3'd5
	} phase_t;

	// size index codes that take the size from trailing bytes
	localparam logic [2:0] IDX_EXT1 = 3'd5;
	localparam logic [2:0] IDX_EXT2 = 3'd6;
	localparam logic [2:0] IDX_EXT4 = 3'd7;

	// nil element type
	localparam logic [4:0] TYPE_NIL = 5'd0;

	// data element header parser state
	typedef struct packed {
		logic        first;
		logic [2:0]  extra;
		logic [31:0] size;
	} hdr_t;

	localparam hdr_t HDR_CLEAR = '{first: 1'b1, extra: 3'd0, size: 32'd0};

endpackage

/* rtl/core/sdp_in_if.sv */
// ----------------------------------------------------------------------------
// sdp_in_if - byte stream channel
// Valid/ready channel carrying one response byte per request.
// ----------------------------------------------------------------------------
interface sdp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

/* rtl/core/sdp_out_if.sv */
// ----------------------------------------------------------------------------
// sdp_out_if - attribute value byte channel
// Valid/ready channel carrying one attribute value byte and its context.
// ----------------------------------------------------------------------------
interface sdp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] record_number;
	logic [15:0] attr_id;
	logic [15:0] value_length;
	logic [15:0] byte_offset;
	logic [7:0]  value_byte;

	modport source (output valid, output record_number, output attr_id,
		output value_length, output byte_offset, output value_byte, input ready);
	modport sink   (input valid, input record_number, input attr_id,
		input value_length, input byte_offset, input value_byte, output ready);
endinterface

/* rtl/core/sdp_hdr.sv */
// ----------------------------------------------------------------------------
// sdp_hdr - data element header decoder
// One byte step of the header parser: size index decode and size bytes.
// ----------------------------------------------------------------------------
module sdp_hdr (
	input  sdp_pkg::hdr_t cur,
	input  logic [7:0]    data_byte,
	output sdp_pkg::hdr_t nxt,
	output logic          done
);

	localparam logic [2:0] IDX_EXT1_C = sdp_pkg::IDX_EXT1;
	localparam logic [2:0] IDX_EXT2_C = sdp_pkg::IDX_EXT2;
	localparam logic [2:0] IDX_EXT4_C = sdp_pkg::IDX_EXT4;

	logic [2:0] idx;
	logic [4:0] typ;

	assign idx = data_byte[2:0];
	assign typ = data_byte[7:3];

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (cur.first) begin
			// descriptor byte
			nxt.size = 32'd0;
			case (idx)
				IDX_EXT1_C: begin
					nxt.extra = 3'd1;
					nxt.first = 1'b0;
				end
				IDX_EXT2_C: begin
					nxt.extra = 3'd2;
					nxt.first = 1'b0;
				end
				IDX_EXT4_C: begin
					nxt.extra = 3'd4;
					nxt.first = 1'b0;
				end
				default: begin
					nxt.extra = 3'd0;
					nxt.size  = (typ == sdp_pkg::TYPE_NIL) ? 32'd0 : (32'd1 << idx);
					done      = 1'b1;
				end
			endcase
		end else begin
			// big endian size bytes
			if (cur.extra != 3'd0) begin
				nxt.size  = {cur.size[23:0], data_byte};
				nxt.extra = cur.extra - 3'd1;
			end
			if (nxt.extra == 3'd0) begin
				nxt.first = 1'b1;
				done      = 1'b1;
			end
		end
	end

endmodule

/* rtl/core/sdp_walker.sv */
// ----------------------------------------------------------------------------
// sdp_walker - element walk state and result register
// Updates the list/record/attribute state for one byte and registers results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdp_walker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  logic [7:0]      byte_s1,
	output logic            take,
	sdp_out_if.source       attr
);

	sdp_pkg::phase_t phase_q, phase_n;
	sdp_pkg::hdr_t   hdr_q, hdr_n, hdr_step;
	logic            hdr_done;
	logic [15:0]     attr_id_q, attr_id_n;
	logic [15:0]     recv_q, recv_n;
	logic [15:0]     deliv_q, deliv_n;
	logic [15:0]     total_q, total_n;
	logic [15:0]     lp_q, lp_n;
	logic [15:0]     list_len_q, list_len_n;
	logic [15:0]     rp_q, rp_n;
	logic [15:0]     rec_len_q, rec_len_n;
	logic [15:0]     rec_idx_q, rec_idx_n;
	logic [31:0]     size_dec;
	logic            emit;
	logic            attr_end;
	logic            out_valid_q;

	sdp_hdr u_hdr (
		.cur       (hdr_q),
		.data_byte (byte_s1),
		.nxt       (hdr_step),
		.done      (hdr_done)
	);

	// a byte moves on when the result register is free or being emptied
	assign take = valid_s1 && (!out_valid_q || attr.ready);

	// next state for one byte
	always_comb begin
		phase_n    = phase_q;
		hdr_n      = hdr_q;
		attr_id_n  = attr_id_q;
		recv_n     = recv_q;
		deliv_n    = deliv_q;
		total_n    = total_q;
		lp_n       = lp_q + 16'd1;
		list_len_n = list_len_q;
		rp_n       = rp_q + 16'd1;
		rec_len_n  = rec_len_q;
		rec_idx_n  = rec_idx_q;
		size_dec   = (hdr_q.size != 32'd0) ? (hdr_q.size - 32'd1) : hdr_q.size;
		emit       = 1'b0;
		attr_end   = 1'b0;
		case (phase_q)
			sdp_pkg::PH_LIST: begin
				hdr_n = hdr_step;
				if (hdr_done) begin
					lp_n       = 16'd0;
					list_len_n = hdr_step.size[15:0];
					rec_idx_n  = 16'd0;
					phase_n    = sdp_pkg::PH_RECORD;
				end
			end
			sdp_pkg::PH_RECORD: begin
				hdr_n = hdr_step;
				if (hdr_done) begin
					rp_n      = 16'd0;
					rec_len_n = hdr_step.size[15:0];
					phase_n   = sdp_pkg::PH_IDHDR;
				end
			end
			sdp_pkg::PH_IDHDR: begin
				hdr_n = hdr_step;
				if (hdr_done) begin
					attr_id_n = 16'd0;
					phase_n   = sdp_pkg::PH_ID;
				end
			end
			sdp_pkg::PH_ID: begin
				// zero-length ID still takes one byte
				attr_id_n  = {attr_id_q[7:0], byte_s1};
				hdr_n.size = size_dec;
				if (size_dec == 32'd0) begin
					phase_n = sdp_pkg::PH_VALHDR;
					recv_n  = 16'd0;
					deliv_n = 16'd0;
					total_n = 16'd0;
					hdr_n   = sdp_pkg::HDR_CLEAR;
				end
			end
			sdp_pkg::PH_VALHDR: begin
				recv_n  = recv_q + 16'd1;
				deliv_n = deliv_q + 16'd1;
				emit    = 1'b1;
				hdr_n   = hdr_step;
				if (hdr_done) begin
					total_n = hdr_step.size[15:0] + recv_n;
					if (hdr_step.size == 32'd0) begin
						attr_end = 1'b1;
					end else begin
						phase_n = sdp_pkg::PH_VALUE;
					end
				end
			end
			sdp_pkg::PH_VALUE: begin
				recv_n  = recv_q + 16'd1;
				deliv_n = deliv_q + 16'd1;
				emit    = 1'b1;
				if (recv_n >= total_q) begin
					attr_end = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// end of attribute: next attribute, next record or back to list
		if (attr_end) begin
			if (rp_n != rec_len_q) begin
				phase_n = sdp_pkg::PH_IDHDR;
			end else begin
				rp_n = 16'd0;
				if (list_len_q != 16'd0 && lp_n != list_len_q) begin
					rec_idx_n = rec_idx_q + 16'd1;
					phase_n   = sdp_pkg::PH_RECORD;
				end else begin
					lp_n      = 16'd0;
					hdr_n     = sdp_pkg::HDR_CLEAR;
					rec_idx_n = 16'd0;
					phase_n   = sdp_pkg::PH_LIST;
				end
			end
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= sdp_pkg::PH_LIST;
			hdr_q      <= sdp_pkg::HDR_CLEAR;
			attr_id_q  <= 16'd0;
			recv_q     <= 16'd0;
			deliv_q    <= 16'd0;
			total_q    <= 16'd0;
			lp_q       <= 16'd0;
			list_len_q <= 16'd0;
			rp_q       <= 16'd0;
			rec_len_q  <= 16'd0;
			rec_idx_q  <= 16'd0;
		end else if (take) begin
			phase_q    <= phase_n;
			hdr_q      <= hdr_n;
			attr_id_q  <= attr_id_n;
			recv_q     <= recv_n;
			deliv_q    <= deliv_n;
			total_q    <= total_n;
			lp_q       <= lp_n;
			list_len_q <= list_len_n;
			rp_q       <= rp_n;
			rec_len_q  <= rec_len_n;
			rec_idx_q  <= rec_idx_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (attr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, taken from the state before the update
	always_ff @(posedge clk) begin
		if (take && emit) begin
			attr.record_number <= rec_idx_q;
			attr.attr_id       <= attr_id_q;
			attr.value_length  <= total_q;
			attr.byte_offset   <= deliv_q;
			attr.value_byte    <= byte_s1;
		end
	end

	assign attr.valid = out_valid_q;

	// record index only counts inside a list
	`SDP_ASSERT(a_list_idx_zero, clk, arst_n,
		(phase_q == sdp_pkg::PH_LIST) |-> (rec_idx_q == 16'd0))
	// a pending size byte count goes with a header in progress
	`SDP_ASSERT(a_hdr_extra, clk, arst_n, (!hdr_q.first) |-> (hdr_q.extra != 3'd0))
	// ID and value body phases start only after a complete header
	`SDP_ASSERT(a_hdr_closed, clk, arst_n,
		(phase_q == sdp_pkg::PH_ID || phase_q == sdp_pkg::PH_VALUE) |-> hdr_q.first)
	// a value byte that moves on shows up as a result next cycle
	`SDP_ASSERT(a_emit_valid, clk, arst_n, (take && emit) |=> out_valid_q)

endmodule

/* rtl/core/sdp_attribute_stream_parser.sv */
// ----------------------------------------------------------------------------
// sdp_attribute_stream_parser - service attribute list byte stream parser
// Walks list, record, attribute ID and value headers; emits value bytes.
// ----------------------------------------------------------------------------
// Usage:
//   stream : one byte of the attribute list response per request.
//   attr   : one request per attribute value byte (header bytes included),
//            with record number, attribute ID, value length and offset.
//            Value length reads zero while the value header is arriving.
//   Bytes outside attribute values (list, record and ID headers, ID bytes)
//   are consumed and produce no request on attr.
// Timing:
//   One byte per cycle sustained while attr does not stall. An accepted byte
//   waits in the input register; the walk state update then writes its
//   result into the result register, from which the result is offered.
//   The rate is set by the combinational state update loop.
// Reset:
//   arst_n clears the walk to the list header phase and drops both stages.
// Stall:
//   While attr is stalled with a result waiting, the input register still
//   takes one byte; further bytes wait on stream.ready until attr drains.
// ----------------------------------------------------------------------------
module sdp_attribute_stream_parser (
	input  logic      clk,
	input  logic      arst_n,
	sdp_in_if.sink    stream,
	sdp_out_if.source attr
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	logic       accept;

	assign stream.ready = !valid_s1 || take;
	assign accept       = stream.valid && stream.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= stream.data_byte;
		end
	end

	sdp_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.take     (take),
		.attr     (attr)
	);

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for sdp_attribute_stream_parser
// Feeds attribute list response bytes (directed cases, random well-formed
// lists, broken lists and raw noise) with random gaps and output stalls.
// A local copy of the element walk predicts each value byte request, and the
// checker compares every field of each result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_PCT    = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// each random test stops once this many bytes in total have gone out
	localparam int unsigned RANDOM_END = 1560;
	localparam int unsigned BROKEN_END = 1740;
	localparam int unsigned NOISE_END  = 1880;

	// element type codes used by the stream builder
	localparam logic [4:0] KIND_UINT = 5'd1;
	localparam logic [4:0] KIND_TEXT = 5'd4;
	localparam logic [4:0] KIND_SEQ  = 5'd6;
	localparam logic [4:0] KIND_ALT  = 5'd7;
	localparam logic [4:0] KIND_RSVD = 5'd31;

	// fixed size indexes
	localparam logic [2:0] IDX_1B = 3'd0;
	localparam logic [2:0] IDX_2B = 3'd1;
	localparam logic [2:0] IDX_4B = 3'd2;

	typedef struct packed {
		logic [15:0] record_number;
		logic [15:0] attr_id;
		logic [15:0] value_length;
		logic [15:0] byte_offset;
		logic [7:0]  value_byte;
	} attr_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	sdp_in_if  stream_ch ();
	sdp_out_if attr_ch ();

	sdp_attribute_stream_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.attr   (attr_ch)
	);

	always #10 clk = ~clk;

	// predicted value byte requests, oldest first
	attr_byte_t expected_bytes[$];
	// bytes waiting to be sent
	logic [7:0] stream_q[$];

	int unsigned bytes_sent = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          src_idle_pct = IDLE_PCT;
	int          sink_idle_pct = IDLE_PCT;
	bit          hold_req = 1'b0;
	bit          sink_hold = 1'b0;

	// ------------------------------------------------------------------
	// element walk predictor
	// ------------------------------------------------------------------
	sdp_pkg::phase_t walk_phase;
	logic        hdr_first;
	logic [2:0]  hdr_extra;
	logic [31:0] hdr_size;
	logic [15:0] id_acc;
	logic [15:0] val_rcvd;
	logic [15:0] val_sent;
	logic [15:0] val_total;
	logic [15:0] list_pos;
	logic [15:0] list_len;
	logic [15:0] rec_pos;
	logic [15:0] rec_len;
	logic [15:0] rec_idx;

	function automatic void hdr_clear();
		hdr_first = 1'b1;
		hdr_extra = 3'd0;
		hdr_size  = 32'd0;
	endfunction

	function automatic void walk_reset();
		walk_phase = sdp_pkg::PH_LIST;
		hdr_clear();
		id_acc    = '0;
		val_rcvd  = '0;
		val_sent  = '0;
		val_total = '0;
		list_pos  = '0;
		list_len  = '0;
		rec_pos   = '0;
		rec_len   = '0;
		rec_idx   = '0;
	endfunction

	// one byte into the header parser; returns 1 when the header is done
	function automatic bit hdr_take(input logic [7:0] b);
		logic [2:0] idx;
		logic [4:0] kind;
		idx  = b[2:0];
		kind = b[7:3];
		if (hdr_first) begin
			hdr_size = 32'd0;
			if (idx >= sdp_pkg::IDX_EXT1) begin
				hdr_extra = (idx == sdp_pkg::IDX_EXT1) ? 3'd1 :
					(idx == sdp_pkg::IDX_EXT2) ? 3'd2 : 3'd4;
				hdr_first = 1'b0;
				return 1'b0;
			end
			hdr_extra = 3'd0;
			hdr_size  = (kind == sdp_pkg::TYPE_NIL) ? 32'd0 : (32'd1 << idx);
			return 1'b1;
		end
		if (hdr_extra != 3'd0) begin
			hdr_size  = {hdr_size[23:0], b};
			hdr_extra = hdr_extra - 3'd1;
		end
		if (hdr_extra != 3'd0)
			return 1'b0;
		hdr_first = 1'b1;
		return 1'b1;
	endfunction

	// value finished: next attribute, next record or back to list header
	function automatic void attr_end();
		if (rec_pos != rec_len) begin
			walk_phase = sdp_pkg::PH_IDHDR;
		end else begin
			rec_pos = '0;
			if (list_len != 16'd0 && list_pos != list_len) begin
				rec_idx    = rec_idx + 16'd1;
				walk_phase = sdp_pkg::PH_RECORD;
			end else begin
				list_pos = '0;
				hdr_clear();
				walk_phase = sdp_pkg::PH_LIST;
				rec_idx    = '0;
			end
		end
	endfunction

	function automatic void emit_expect(input logic [7:0] b);
		attr_byte_t e;
		e.record_number = rec_idx;
		e.attr_id       = id_acc;
		e.value_length  = val_total;
		e.byte_offset   = val_sent;
		e.value_byte    = b;
		expected_bytes.push_back(e);
		val_sent = val_sent + 16'd1;
	endfunction

	function automatic void walk_byte(input logic [7:0] b);
		list_pos = list_pos + 16'd1;
		rec_pos  = rec_pos + 16'd1;
		case (walk_phase)
			sdp_pkg::PH_LIST: begin
				if (hdr_take(b)) begin
					list_pos   = '0;
					list_len   = hdr_size[15:0];
					rec_idx    = '0;
					walk_phase = sdp_pkg::PH_RECORD;
				end
			end
			sdp_pkg::PH_RECORD: begin
				if (hdr_take(b)) begin
					rec_pos    = '0;
					rec_len    = hdr_size[15:0];
					walk_phase = sdp_pkg::PH_IDHDR;
				end
			end
			sdp_pkg::PH_IDHDR: begin
				if (hdr_take(b)) begin
					id_acc     = '0;
					walk_phase = sdp_pkg::PH_ID;
				end
			end
			sdp_pkg::PH_ID: begin
				id_acc = {id_acc[7:0], b};
				// a zero-length ID still takes one byte
				if (hdr_size != 32'd0)
					hdr_size = hdr_size - 32'd1;
				if (hdr_size == 32'd0) begin
					walk_phase = sdp_pkg::PH_VALHDR;
					val_rcvd   = '0;
					val_sent   = '0;
					val_total  = '0;
					hdr_clear();
				end
			end
			sdp_pkg::PH_VALHDR: begin
				val_rcvd = val_rcvd + 16'd1;
				emit_expect(b);
				if (hdr_take(b)) begin
					val_total = hdr_size[15:0] + val_rcvd;
					// empty value is complete with its header
					if (hdr_size == 32'd0)
						attr_end();
					else
						walk_phase = sdp_pkg::PH_VALUE;
				end
			end
			sdp_pkg::PH_VALUE: begin
				val_rcvd = val_rcvd + 16'd1;
				emit_expect(b);
				if (val_rcvd >= val_total)
					attr_end();
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stream side
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		stream_ch.valid     <= 1'b1;
		stream_ch.data_byte <= b;
		do @(posedge clk); while (!stream_ch.ready);
		walk_byte(b);
		bytes_sent++;
		// random gap before the next request
		if ($urandom_range(99) < src_idle_pct) begin
			stream_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
	endtask

	task automatic flush_stream();
		while (stream_q.size() != 0)
			send_byte(stream_q.pop_front());
	endtask

	task automatic drain_results();
		stream_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// stream builder
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic void put_hdr(input logic [4:0] kind, input logic [2:0] idx);
		stream_q.push_back({kind, idx});
	endfunction

	// put a header in front of everything queued since position at
	function automatic void close_elem(input int at, input logic [4:0] kind,
			input bit allow_fixed);
		int unsigned len;
		int          nb;
		logic [2:0]  idx;
		len = stream_q.size() - at;
		if (allow_fixed && kind != sdp_pkg::TYPE_NIL && $urandom_range(1) == 0 &&
				(len == 1 || len == 2 || len == 4 || len == 8 || len == 16)) begin
			idx = 3'($clog2(len));
			nb  = 0;
		end else begin
			case ($urandom_range(2))
				0:       idx = (len < 256) ? sdp_pkg::IDX_EXT1 : sdp_pkg::IDX_EXT2;
				1:       idx = sdp_pkg::IDX_EXT2;
				default: idx = sdp_pkg::IDX_EXT4;
			endcase
			nb = (idx == sdp_pkg::IDX_EXT1) ? 1 : (idx == sdp_pkg::IDX_EXT2) ? 2 : 4;
		end
		// low byte first, each insert pushes the earlier ones back
		for (int k = 0; k < nb; k++)
			stream_q.insert(at, len[8*k +: 8]);
		stream_q.insert(at, {kind, idx});
	endfunction

	function automatic void add_attribute();
		int at;
		int n;
		int r;
		// attribute ID
		case ($urandom_range(7))
			0: begin
				put_hdr(sdp_pkg::TYPE_NIL, IDX_1B);
				stream_q.push_back(rand_byte());
			end
			1: begin
				put_hdr(KIND_UINT, sdp_pkg::IDX_EXT1);
				stream_q.push_back(8'h00);
				stream_q.push_back(rand_byte());
			end
			2: begin
				at = stream_q.size();
				n  = $urandom_range(1, 6);
				repeat (n) stream_q.push_back(rand_byte());
				close_elem(at, KIND_UINT, 1'b1);
			end
			default: begin
				put_hdr(KIND_UINT, IDX_2B);
				stream_q.push_back(rand_byte());
				stream_q.push_back(rand_byte());
			end
		endcase
		// attribute value
		r  = $urandom_range(99);
		at = stream_q.size();
		if (r < 8) begin
			put_hdr(sdp_pkg::TYPE_NIL, IDX_1B);
		end else if (r < 12) begin
			close_elem(at, 5'($urandom_range(31)), 1'b0);
		end else begin
			if (r == 12)
				n = $urandom_range(256, 300);
			else if (r < 30)
				n = 1 << $urandom_range(4);
			else
				n = $urandom_range(1, 24);
			repeat (n) stream_q.push_back(rand_byte());
			close_elem(at, 5'($urandom_range(1, 31)), 1'b1);
		end
	endfunction

	function automatic void add_record();
		int at;
		at = stream_q.size();
		repeat ($urandom_range(1, 4)) add_attribute();
		close_elem(at, KIND_SEQ, 1'b1);
	endfunction

	function automatic void add_list();
		int at;
		at = stream_q.size();
		repeat ($urandom_range(1, 3)) add_record();
		close_elem(at, ($urandom_range(3) == 0) ? KIND_ALT : KIND_SEQ, 1'b1);
	endfunction

	// ------------------------------------------------------------------
	// attr side: random stalls, long hold-off, result check
	// ------------------------------------------------------------------
	always @(posedge clk)
		attr_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);

	// long hold-off, counted here once requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
				hold_req  <= 1'b0;
			end
		end
	end

	task automatic check_value_byte();
		attr_byte_t got;
		attr_byte_t want;
		got.record_number = attr_ch.record_number;
		got.attr_id       = attr_ch.attr_id;
		got.value_length  = attr_ch.value_length;
		got.byte_offset   = attr_ch.byte_offset;
		got.value_byte    = attr_ch.value_byte;
		if (expected_bytes.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: unexpected request rec=%0d id=%h len=%0d off=%0d byte=%h",
					$time, got.record_number, got.attr_id, got.value_length,
					got.byte_offset, got.value_byte);
		end else begin
			want = expected_bytes.pop_front();
			if (got.record_number !== want.record_number || got.attr_id !== want.attr_id ||
					got.value_length !== want.value_length ||
					got.byte_offset !== want.byte_offset ||
					got.value_byte !== want.value_byte) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("%0t: mismatch exp rec=%0d id=%h len=%0d off=%0d byte=%h",
						$time, want.record_number, want.attr_id, want.value_length,
						want.byte_offset, want.value_byte);
					$display("%0t:          got rec=%0d id=%h len=%0d off=%0d byte=%h",
						$time, got.record_number, got.attr_id, got.value_length,
						got.byte_offset, got.value_byte);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && attr_ch.valid && attr_ch.ready)
			check_value_byte();
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[sdp_attribute_stream_parser] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// nil value, zero-size value, zero-length ID, long ID, reserved type
	task automatic test_value_special_cases();
		put_hdr(KIND_SEQ, sdp_pkg::IDX_EXT1);
		stream_q.push_back(8'd17);
		put_hdr(KIND_SEQ, sdp_pkg::IDX_EXT1);
		stream_q.push_back(8'd15);
		put_hdr(KIND_UINT, IDX_2B);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h01);
		put_hdr(sdp_pkg::TYPE_NIL, IDX_1B);
		put_hdr(sdp_pkg::TYPE_NIL, IDX_1B);
		stream_q.push_back(8'h7F);
		put_hdr(KIND_TEXT, sdp_pkg::IDX_EXT1);
		stream_q.push_back(8'h00);
		put_hdr(KIND_UINT, IDX_4B);
		stream_q.push_back(8'hDE);
		stream_q.push_back(8'hAD);
		stream_q.push_back(8'hBE);
		stream_q.push_back(8'hEF);
		put_hdr(KIND_RSVD, IDX_1B);
		stream_q.push_back(8'hFF);
		flush_stream();
		drain_results();
	endtask

	// list header of size zero: back to list phase after one attribute
	task automatic test_zero_list_length();
		put_hdr(sdp_pkg::TYPE_NIL, IDX_1B);
		put_hdr(KIND_SEQ, sdp_pkg::IDX_EXT1);
		stream_q.push_back(8'd5);
		put_hdr(KIND_UINT, IDX_2B);
		stream_q.push_back(8'h12);
		stream_q.push_back(8'h34);
		put_hdr(KIND_UINT, IDX_1B);
		stream_q.push_back(8'h55);
		flush_stream();
		drain_results();
	endtask

	// attr held off while a long value keeps coming; input must stall
	task automatic test_output_backpressure();
		int list_at;
		int rec_at;
		int val_at;
		hold_req <= 1'b1;
		list_at = stream_q.size();
		rec_at  = stream_q.size();
		put_hdr(KIND_UINT, IDX_2B);
		stream_q.push_back(rand_byte());
		stream_q.push_back(rand_byte());
		val_at = stream_q.size();
		repeat (60) stream_q.push_back(rand_byte());
		close_elem(val_at, KIND_TEXT, 1'b0);
		close_elem(rec_at, KIND_SEQ, 1'b0);
		close_elem(list_at, KIND_SEQ, 1'b0);
		flush_stream();
		drain_results();
	endtask

	task automatic test_random_lists();
		int n;
		n = 0;
		while (bytes_sent < RANDOM_END) begin
			// stretch with no gaps and no stalls
			if (n == 8) begin
				src_idle_pct  = 0;
				sink_idle_pct <= 0;
			end
			if (n == 16) begin
				src_idle_pct  = IDLE_PCT;
				sink_idle_pct <= IDLE_PCT;
			end
			if ($urandom_range(9) == 0) begin
				put_hdr(sdp_pkg::TYPE_NIL, IDX_1B);
				add_record();
			end else begin
				add_list();
			end
			flush_stream();
			if (n == 20)
				drain_results();
			n++;
		end
		// gaps and stalls back on for the remaining tests
		src_idle_pct  = IDLE_PCT;
		sink_idle_pct <= IDLE_PCT;
		drain_results();
	endtask

	// well-formed lists with a byte dropped, a byte added or bytes cut off the end
	task automatic test_broken_lists();
		while (bytes_sent < BROKEN_END) begin
			add_list();
			case ($urandom_range(2))
				0: stream_q.delete($urandom_range(stream_q.size() - 1));
				1: stream_q.insert($urandom_range(stream_q.size() - 1), rand_byte());
				default: repeat ($urandom_range(1, stream_q.size() / 2))
					stream_q.delete(stream_q.size() - 1);
			endcase
			flush_stream();
		end
		drain_results();
	endtask

	task automatic test_random_noise();
		while (bytes_sent < NOISE_END)
			send_byte(rand_byte());
		drain_results();
	endtask

	initial begin
		stream_ch.valid     = 1'b0;
		stream_ch.data_byte = 8'h00;
		attr_ch.ready       = 1'b0;
		arst_n              = 1'b0;
		walk_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_value_special_cases();
		test_zero_list_length();
		test_output_backpressure();
		test_random_lists();
		test_broken_lists();
		test_random_noise();

		if (fail_count == 0 && expected_bytes.size() == 0)
			$display("[sdp_attribute_stream_parser] OK");
		else
			$display("[sdp_attribute_stream_parser] ERROR");
		$finish;
	end

endmodule

/* sdp_attribute_stream_parser.f */
+incdir+rtl/core
rtl/core/sdp_pkg.sv
rtl/core/sdp_in_if.sv
rtl/core/sdp_out_if.sv
rtl/core/sdp_hdr.sv
rtl/core/sdp_walker.sv
rtl/core/sdp_attribute_stream_parser.sv
test/tb.sv
